// ----- hw/rtl/three_axis_moving_average_assert.svh -----
// Assertion macros for the three-axis moving average
`ifndef THREE_AXIS_MOVING_AVERAGE_ASSERT_SVH
`define THREE_AXIS_MOVING_AVERAGE_ASSERT_SVH

// same-cycle implication, reset masked
`define TAMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define TAMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/tama_pkg.sv -----
// Package: sizes, scaling constants and control structs for the moving average
`timescale 1ns / 1ps
package tama_pkg;

  localparam int WINDOW   = 10;
  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 21;
  localparam int IDX_W    = $clog2(WINDOW);
  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);

  // round(|sum| * 16 / WINDOW) = floor((|sum| * 32 + WINDOW) / (2 * WINDOW))
  localparam int N_W      = SUM_W + 5;
  localparam int DIV      = 2 * WINDOW;
  localparam int DIV_LOG  = $clog2(DIV);
  localparam int SH       = N_W + DIV_LOG;
  localparam int RECIP_W  = N_W + 1;
  localparam int PROD_W   = N_W + RECIP_W;
  localparam int Q_W      = OUT_W - 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV));

  typedef struct packed {
    logic             fill;
    logic             wr;
    logic [IDX_W-1:0] idx;
  } ring_ctrl_t;

  typedef struct packed {
    logic ld2;
    logic ld3;
  } stage_ctrl_t;

endpackage

// ----- hw/rtl/tama_axis.sv -----
// One axis: sample ring and running window sum
`timescale 1ns / 1ps
module tama_axis
  import tama_pkg::*;
(
  input  logic                       clk,
  input  ring_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic signed [SUM_W-1:0]    sum
);

  localparam logic signed [SUM_W-1:0] WIN_S = SUM_W'(WINDOW);

  logic signed [SAMPLE_W-1:0] ring_r [WINDOW];
  logic signed [SUM_W-1:0]    acc_r;
  logic signed [SUM_W-1:0]    acc_nxt;
  logic signed [SUM_W-1:0]    s_ext;
  logic signed [SUM_W-1:0]    old_ext;

  assign s_ext   = {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
  assign old_ext = {{(SUM_W-SAMPLE_W){ring_r[ctrl.idx][SAMPLE_W-1]}}, ring_r[ctrl.idx]};

  always_comb begin
    if (ctrl.fill) begin
      acc_nxt = s_ext * WIN_S;
    end else begin
      acc_nxt = acc_r + s_ext - old_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fill) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_r[i] <= sample;
      end
    end else if (ctrl.wr) begin
      ring_r[ctrl.idx] <= sample;
    end
    if (ctrl.fill || ctrl.wr) begin
      acc_r <= acc_nxt;
    end
  end

  assign sum = acc_r;

endmodule

// ----- hw/rtl/tama_scale.sv -----
// Two-stage scaling of a window sum to 1/131072 g, rounded, optionally negated
`timescale 1ns / 1ps
module tama_scale
  import tama_pkg::*;
(
  input  logic                    clk,
  input  stage_ctrl_t             ctrl,
  input  logic                    negate,
  input  logic signed [SUM_W-1:0] sum,
  output logic [OUT_W-1:0]        result
);

  logic [SUM_W-1:0]  mag;
  logic [N_W-1:0]    n_nxt;
  logic [N_W-1:0]    n_r;
  logic              neg_r;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q;
  logic [OUT_W-1:0]  res_nxt;
  logic [OUT_W-1:0]  res_r;

  // stage 2: magnitude and rounding offset
  assign mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign n_nxt = {mag, 5'b0} + N_W'(WINDOW);

  // stage 3: reciprocal multiply, sign
  assign prod    = PROD_W'(n_r) * PROD_W'(RECIP);
  assign q       = prod[SH +: Q_W];
  assign res_nxt = neg_r ? OUT_W'(-{1'b0, q}) : {1'b0, q};

  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      n_r   <= n_nxt;
      neg_r <= sum[SUM_W-1] ^ negate;
    end
    if (ctrl.ld3) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;

endmodule

// ----- hw/rtl/three_axis_moving_average.sv -----
// Pipeline: an accepted in_ word passes the sum, offset and multiply registers before
// out_tvalid. Throughput: one word per cycle while the output is not held; each stage
// has its own valid, so a held output stalls only the stages behind it.
// Reset: rst_n (sync, low) clears stage valids, write index and the primed flag.
// The sample rings are not cleared; the first word after reset fills them.
`timescale 1ns / 1ps
`include "three_axis_moving_average_assert.svh"
module three_axis_moving_average
  import tama_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // accel_x, accel_y, accel_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // mean_x_g, mean_y_g, mean_z_g, zero pad
);

  logic             v1_r, v2_r, v3_r;
  logic             v1_nxt, v2_nxt, v3_nxt;
  logic             rdy1, rdy2, rdy3;
  logic             accept;
  logic             primed_r, primed_nxt;
  logic [IDX_W-1:0] wi_r, wi_nxt;
  ring_ctrl_t       rctl;
  stage_ctrl_t      sctl;

  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic [OUT_W-1:0]        res_x, res_y, res_z;

  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign accept    = in_tvalid && rdy1;

  assign sctl.ld2 = v1_r && rdy2;
  assign sctl.ld3 = v2_r && rdy3;

  assign rctl.fill = accept && !primed_r;
  assign rctl.wr   = accept && primed_r;
  assign rctl.idx  = wi_r;

  always_comb begin
    primed_nxt = primed_r;
    wi_nxt     = wi_r;
    if (rctl.fill) begin
      primed_nxt = 1'b1;
    end else if (rctl.wr) begin
      wi_nxt = (wi_r == IDX_W'(WINDOW - 1)) ? '0 : wi_r + 1'b1;
    end
    v1_nxt = accept ? 1'b1 : (sctl.ld2 ? 1'b0 : v1_r);
    v2_nxt = sctl.ld2 ? 1'b1 : (sctl.ld3 ? 1'b0 : v2_r);
    v3_nxt = sctl.ld3 ? 1'b1 : (out_tready ? 1'b0 : v3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      primed_r <= 1'b0;
      wi_r     <= '0;
    end else begin
      v1_r     <= v1_nxt;
      v2_r     <= v2_nxt;
      v3_r     <= v3_nxt;
      primed_r <= primed_nxt;
      wi_r     <= wi_nxt;
    end
  end

  tama_axis u_axis_x (.clk(clk), .ctrl(rctl), .sample(in_tdata[15:0]),  .sum(sum_x));
  tama_axis u_axis_y (.clk(clk), .ctrl(rctl), .sample(in_tdata[31:16]), .sum(sum_y));
  tama_axis u_axis_z (.clk(clk), .ctrl(rctl), .sample(in_tdata[47:32]), .sum(sum_z));

  tama_scale u_scale_x (.clk(clk), .ctrl(sctl), .negate(1'b1), .sum(sum_x), .result(res_x));
  tama_scale u_scale_y (.clk(clk), .ctrl(sctl), .negate(1'b1), .sum(sum_y), .result(res_y));
  tama_scale u_scale_z (.clk(clk), .ctrl(sctl), .negate(1'b0), .sum(sum_z), .result(res_z));

  assign out_tvalid = v3_r;
  assign out_tdata  = {1'b0, res_z, res_y, res_x};

  `TAMA_ASSERT_NEXT(a_accept_primes, accept, v1_r && primed_r, "accepted word not staged")
  `TAMA_ASSERT_NOW(a_idx_range, 1'b1, wi_r <= IDX_W'(WINDOW - 1), "write index out of range")
  `TAMA_ASSERT_NOW(a_unprimed_idle, !primed_r, wi_r == '0 && !v1_r, "index moved before priming")
  `TAMA_ASSERT_NEXT(a_hold_result, v3_r && !out_tready, v3_r, "held result dropped")

endmodule
